/* rtl/d2h_pkg.sv */
// ----------------------------------------------------------------------------
// d2h_pkg
// shared constants and stage-to-stage types for the double-to-half converter
// ----------------------------------------------------------------------------
`default_nettype none
package d2h_pkg;
    localparam logic [63:0] MAG_TWO_P16   = 64'h40F0_0000_0000_0000;
    localparam logic [63:0] MAG_HALF_MAX  = 64'h40EF_FC00_0000_0000;
    localparam logic [63:0] MAG_TWO_M24   = 64'h3E70_0000_0000_0000;
    localparam logic [63:0] MAG_TWO_M14   = 64'h3F10_0000_0000_0000;
    localparam logic [10:0] EXP_SPECIAL   = 11'h7FF;
    localparam logic [10:0] SUB_SHIFT_TOP = 11'd1051;
    localparam logic [15:0] HALF_POS_INF  = 16'h7C00;
    localparam logic [15:0] HALF_QNAN     = 16'h7E00;
    localparam logic [15:0] HALF_MAX_POS  = 16'h7BFF;
    localparam logic [15:0] HALF_NEG_INF  = 16'hFC00;
    localparam logic [15:0] HALF_NEG_TINY = 16'h8001;
    localparam logic [15:0] HALF_REBIAS   = 16'h3C00;

    typedef enum logic [2:0] {
        KIND_FIXED = 3'b001,
        KIND_SUB   = 3'b010,
        KIND_NORM  = 3'b100
    } kind_t;

    // stage one result: classification plus the raw pieces
    typedef struct packed {
        logic        neg;
        kind_t       kind;
        logic [15:0] fixed;
        logic [10:0] expo;
        logic [51:0] frac;
    } cls_t;

    // stage two result: truncated value and the round-up decision
    typedef struct packed {
        logic        neg;
        logic        fixed_sel;
        logic [15:0] base;
        logic        bump;
    } trn_t;
endpackage
`default_nettype wire

/* rtl/double_to_half_round_down.sv */
// pipeline: three register stages from input transaction to result valid
// throughput: one transaction per cycle while the output is not stalled; each stage is an elastic register
// that advances whenever its successor is free, so stalls lose nothing
// reset: synchronous, active low, clears the stage valid bits only
// ----------------------------------------------------------------------------
// double_to_half_round_down
// converts a binary64 pattern to binary16, rounding toward negative infinity
// ----------------------------------------------------------------------------
`default_nettype none
module double_to_half_round_down (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_double_bits,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_half_bits
);
    // stage valid bits and pipeline enables
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v3_reg;

    // ---------------- stage 1: classify on the raw bits ----------------
    d2h_pkg::cls_t c1_next, c1_reg;
    logic [62:0] mag;
    logic [10:0] e_in;
    logic [51:0] f_in;
    logic        n_in;
    always_comb begin
        n_in = s_double_bits[63];
        mag  = s_double_bits[62:0];
        e_in = s_double_bits[62:52];
        f_in = s_double_bits[51:0];
        c1_next.neg   = n_in;
        c1_next.expo  = e_in;
        c1_next.frac  = f_in;
        c1_next.kind  = d2h_pkg::KIND_FIXED;
        c1_next.fixed = {n_in, 15'd0};
        if (e_in == d2h_pkg::EXP_SPECIAL) begin
            // infinity keeps sign, nan becomes quiet with top payload bits
            if (f_in == 52'd0) begin
                c1_next.fixed = {n_in, 15'd0} | d2h_pkg::HALF_POS_INF;
            end else begin
                c1_next.fixed = {n_in, 15'd0} | d2h_pkg::HALF_QNAN | {6'd0, f_in[51:42]};
            end
        end else if (!n_in && {1'b0, mag} >= d2h_pkg::MAG_TWO_P16) begin
            c1_next.fixed = d2h_pkg::HALF_MAX_POS;
        end else if (n_in && {1'b0, mag} > d2h_pkg::MAG_HALF_MAX) begin
            c1_next.fixed = d2h_pkg::HALF_NEG_INF;
        end else if ({1'b0, mag} < d2h_pkg::MAG_TWO_M24) begin
            // tiny: +0, -0, or smallest negative subnormal
            if (n_in && mag != 63'd0) begin
                c1_next.fixed = d2h_pkg::HALF_NEG_TINY;
            end
        end else if ({1'b0, mag} < d2h_pkg::MAG_TWO_M14) begin
            c1_next.kind = d2h_pkg::KIND_SUB;
        end else begin
            c1_next.kind = d2h_pkg::KIND_NORM;
        end
    end

    // ---------------- stage 2: truncate and find sticky bits ----------------
    d2h_pkg::trn_t t2_next, t2_reg;
    logic [52:0]  sig;
    logic [5:0]   sh;
    logic [10:0]  sh_full;
    logic [105:0] shifted;
    always_comb begin
        sig      = {1'b1, c1_reg.frac};
        sh_full  = d2h_pkg::SUB_SHIFT_TOP - c1_reg.expo;
        sh       = sh_full[5:0];
        shifted  = {sig, 53'd0} >> sh;
        t2_next.neg       = c1_reg.neg;
        t2_next.fixed_sel = (c1_reg.kind == d2h_pkg::KIND_FIXED);
        t2_next.base      = c1_reg.fixed;
        t2_next.bump      = 1'b0;
        case (c1_reg.kind)
            d2h_pkg::KIND_SUB: begin
                // subnormal: fraction is the integer part, sticky from the rest
                t2_next.base = {5'd0, shifted[63:53]};
                t2_next.bump = c1_reg.neg && (shifted[52:0] != 53'd0);
            end
            d2h_pkg::KIND_NORM: begin
                // normal: exponent minus 1008, which on the low five bits
                // of an in-range exponent just flips bit four
                t2_next.base = {1'b0, ~c1_reg.expo[4], c1_reg.expo[3:0],
                                c1_reg.frac[51:42]};
                t2_next.bump = c1_reg.neg && (c1_reg.frac[41:0] != 42'd0);
            end
            default: begin
            end
        endcase
    end

    // ---------------- stage 3: round-up add and sign merge ----------------
    logic [15:0] h3_next, h3_reg;
    logic [14:0] rounded;
    always_comb begin
        rounded = t2_reg.base[14:0] + {14'd0, t2_reg.bump};
        if (t2_reg.fixed_sel) begin
            h3_next = t2_reg.base;
        end else begin
            h3_next = {t2_reg.neg, rounded};
        end
    end
    assign m_half_bits = h3_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (en1) c1_reg <= c1_next;
        if (en2) t2_reg <= t2_next;
        if (en3) h3_reg <= h3_next;
    end

`ifndef SYNTHESIS
    // a held result must not change while waiting
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_half_bits))
        else $error("result changed under stall");
    // ready is high whenever the output stage is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !v3_reg |-> s_ready)
        else $error("input stalled with empty output stage");
    // a positive input never yields a negative subnormal or normal result
    a_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && en3 && !t2_reg.neg && !t2_reg.fixed_sel |=> !m_half_bits[15])
        else $error("sign flipped on positive value");
`endif
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives binary64 patterns into the converter and checks every binary16
// result against a behavioral model of round-toward-negative conversion
// ----------------------------------------------------------------------------
module testbench;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_double_bits = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_half_bits;

    // queue of half patterns still owed by the block
    logic [15:0] half_expected_q[$];
    int          error_count = 0;
    int          sent_count = 0;
    int          checked_count = 0;
    bit          rx_stall_mode = 1'b0;

    double_to_half_round_down i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_double_bits(s_double_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_half_bits  (m_half_bits)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // bit-level model of the conversion, rounding toward negative infinity
    function automatic logic [15:0] half_round_down(input logic [63:0] x);
        logic [15:0] sgn;
        logic        neg;
        logic [63:0] mag;
        logic [10:0] expo;
        logic [51:0] frac;
        logic [63:0] sig;
        logic [63:0] kept;
        int          sh;
        sgn  = {x[63], 15'd0};
        neg  = x[63];
        mag  = {1'b0, x[62:0]};
        expo = x[62:52];
        frac = x[51:0];
        // infinities keep sign, nans become quiet with top payload bits
        if (expo == 11'h7FF) begin
            if (frac == '0) return sgn | 16'h7C00;
            return sgn | 16'h7E00 | {6'd0, frac[51:42]};
        end
        // overflow: positive saturates, negative goes to -inf
        if (!neg && mag >= 64'h40F0_0000_0000_0000) return 16'h7BFF;
        if (neg && mag > 64'h40EF_FC00_0000_0000) return 16'hFC00;
        // below the smallest subnormal
        if (mag < 64'h3E70_0000_0000_0000) begin
            if (neg && mag != '0) return 16'h8001;
            return sgn;
        end
        // subnormal half result
        if (mag < 64'h3F10_0000_0000_0000) begin
            sig = {11'd0, 1'b1, frac};
            sh  = 1051 - int'(expo);
            kept = sig >> sh;
            if (neg && ((sig & ((64'd1 << sh) - 64'd1)) != '0)) kept = kept + 64'd1;
            return sgn | kept[15:0];
        end
        // normal half result: truncate then rebias
        kept = mag & 64'h7FFF_FC00_0000_0000;
        if (neg && (mag & 64'h0000_03FF_FFFF_FFFF) != '0)
            kept = kept + 64'h0000_0400_0000_0000;
        kept = kept - 64'h3F00_0000_0000_0000;
        return sgn | {1'b0, kept[56:42]};
    endfunction

    // send one transaction, holding valid until accepted
    task automatic send_double(input logic [63:0] bits);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_double_bits <= bits;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        half_expected_q.push_back(half_round_down(bits));
        sent_count++;
    endtask

    task automatic drop_valid();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // random gap between bursts
    task automatic idle_gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        if (n > 0) begin
            drop_valid();
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // receiver: stalls in a mode that changes now and then
    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) rx_stall_mode <= ~rx_stall_mode;
        if (rx_stall_mode) m_ready <= ($urandom_range(0, 2) != 0);
        else m_ready <= 1'b1;
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (half_expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, m_half_bits);
                error_count++;
            end else begin
                logic [15:0] want;
                want = half_expected_q.pop_front();
                if (m_half_bits !== want) begin
                    $display("%0t: half_bits mismatch, expected %h, actual %h",
                             $time, want, m_half_bits);
                    error_count++;
                end
                checked_count++;
            end
        end
    end

    // directed: specials, thresholds, rounding edges for both signs
    task automatic test_directed();
        logic [63:0] pats[$];
        pats = '{64'h0, 64'h8000_0000_0000_0000,
                 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                 64'h7FF8_0000_0000_0001, 64'hFFF7_FFFF_FFFF_FFFF,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'h40F0_0000_0000_0000,
                 64'h40EF_FFFF_FFFF_FFFF, 64'hC0EF_FC00_0000_0000,
                 64'hC0EF_FC00_0000_0001, 64'h0000_0000_0000_0001,
                 64'h8000_0000_0000_0001, 64'h3E6F_FFFF_FFFF_FFFF,
                 64'hBE6F_FFFF_FFFF_FFFF, 64'h3E70_0000_0000_0000,
                 64'hBE70_0000_0000_0001, 64'hBF0F_FFFF_FFFF_FFFF,
                 64'h3F10_0000_0000_0000, 64'hBF10_0000_0000_0001,
                 64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0001,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hC0EF_FBFF_FFFF_FFFF};
        foreach (pats[i]) send_double(pats[i]);
        drop_valid();
    endtask

    // random: mostly exponents near the half range, some fully random patterns
    task automatic test_random(input int count);
        logic [63:0] bits;
        int          burst;
        int          done;
        done = 0;
        while (done < count) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                bits = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0, 1: ;
                    2: bits[62:52] = 11'h7FF;
                    3: bits[62:52] = 11'(999 + $urandom_range(0, 10));
                    4: bits[41:0] = ($urandom_range(0, 1) != 0) ? '0 : bits[41:0];
                    default: bits[62:52] = 11'(990 + $urandom_range(0, 50));
                endcase
                send_double(bits);
                done++;
            end
            idle_gap();
        end
        drop_valid();
    endtask

    // sender holds off until the pipeline has drained
    task automatic test_drain_pause();
        while (half_expected_q.size() != 0) @(posedge aclk);
        test_random(50);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(1000);
        test_drain_pause();
        test_random(1000);
        while (half_expected_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        $display("covered %0d transactions: specials, overflow, tiny, subnormal, normal",
                 sent_count);
        $display("checked %0d results, %0d mismatches", checked_count, error_count);
        if (error_count == 0 && half_expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
